[rtl/core/cbfc_pkg.sv]
// Shared types, register indexes, reset values and a pixel format check helper
// for the clipped blit format convert core. No dependencies.
package cbfc_pkg;

    localparam int DEF_MAX_DIM = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int OFFS_W     = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_PITCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_BPP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BPP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd7;

    localparam logic [12:0] RST_DEST_WIDTH  = 13'd640;
    localparam logic [12:0] RST_DEST_HEIGHT = 13'd480;
    localparam logic [14:0] RST_DEST_PITCH  = 15'd2560;
    localparam logic [2:0]  RST_DEST_BPP    = 3'd4;
    localparam logic [12:0] RST_SRC_WIDTH   = 13'd640;
    localparam logic [2:0]  RST_SRC_BPP     = 3'd4;

    localparam logic [2:0] BPP_3 = 3'd3;
    localparam logic [2:0] BPP_4 = 3'd4;
    localparam logic [7:0] ALPHA_BYTE = 8'hff;

    typedef struct packed {
        logic [12:0]        dest_width;
        logic [12:0]        dest_height;
        logic [14:0]        dest_pitch;
        logic [2:0]         dest_bpp;
        logic [12:0]        src_width;
        logic [2:0]         src_bpp;
        logic signed [13:0] offset_x;
        logic signed [13:0] offset_y;
    } t_cfg;

    typedef struct packed {
        logic              write_ok;
        logic [OFFS_W-1:0] offset;
    } t_place;

    function automatic logic fmt_ok(input logic [2:0] src_bpp, input logic [2:0] dst_bpp);
        logic s_ok;
        logic d_ok;
        s_ok = src_bpp inside {BPP_3, BPP_4};
        d_ok = dst_bpp inside {BPP_3, BPP_4};
        return s_ok && d_ok;
    endfunction

endpackage

[rtl/core/cbfc_counter.sv]
// Source column / row tracker, advanced once per accepted item.
// Depends on cbfc_pkg.
module cbfc_counter
    import cbfc_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    localparam int CW = $clog2(MAX_DIM)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_last,
    input  logic [12:0]   i_src_width,
    output logic [CW-1:0] o_col,
    output logic [CW-1:0] o_row
);

    localparam int CMPW = (CW + 1 > 13) ? CW + 1 : 13;

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [CW:0]   col_inc;
    logic [CW:0]   row_inc;
    logic          col_wrap;

    always_comb begin
        col_inc  = {1'b0, r_col} + (CW+1)'(1);
        row_inc  = {1'b0, r_row} + (CW+1)'(1);
        col_wrap = (CMPW'(col_inc) >= CMPW'(i_src_width)) ||
                   (col_inc >= (CW+1)'(MAX_DIM));
        n_col = r_col;
        n_row = r_row;
        if (i_adv) begin
            if (i_last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_wrap) begin
                n_col = '0;
                n_row = (row_inc >= (CW+1)'(MAX_DIM)) ? '0 : row_inc[CW-1:0];
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col = r_col;
    assign o_row = r_row;

endmodule

[rtl/core/cbfc_place.sv]
// Destination placement: offset add, clip test and byte offset multiply-add.
// Depends on cbfc_pkg.
module cbfc_place
    import cbfc_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    localparam int CW = $clog2(MAX_DIM)
) (
    input  t_cfg          i_cfg,
    input  logic [CW-1:0] i_col,
    input  logic [CW-1:0] i_row,
    output t_place        o_place
);

    localparam int SW = ((CW > 13) ? CW : 13) + 2;

    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] lim_x;
    logic signed [SW-1:0] lim_y;
    logic                 in_rect;
    logic                 ok;
    logic [27:0]          row_term;
    logic [15:0]          col_term;

    always_comb begin
        x = $signed({{(SW-CW){1'b0}}, i_col}) +
            $signed({{(SW-14){i_cfg.offset_x[13]}}, i_cfg.offset_x});
        y = $signed({{(SW-CW){1'b0}}, i_row}) +
            $signed({{(SW-14){i_cfg.offset_y[13]}}, i_cfg.offset_y});
        lim_x = $signed({{(SW-13){1'b0}}, i_cfg.dest_width});
        lim_y = $signed({{(SW-13){1'b0}}, i_cfg.dest_height});
        in_rect = !x[SW-1] && !y[SW-1] && (x < lim_x) && (y < lim_y);
        ok = in_rect && fmt_ok(i_cfg.src_bpp, i_cfg.dest_bpp);
        // in_rect implies both coordinates fit in 13 bits
        row_term = y[12:0] * i_cfg.dest_pitch;
        col_term = x[12:0] * i_cfg.dest_bpp;
        o_place.write_ok = ok;
        o_place.offset   = ok ? (row_term[OFFS_W-1:0] + {10'b0, col_term}) : '0;
    end

endmodule

[rtl/core/cbfc_convert.sv]
// Pixel byte reorder and alpha fill between three- and four-byte formats.
// Depends on cbfc_pkg.
module cbfc_convert
    import cbfc_pkg::*;
(
    input  logic [31:0] i_px,
    input  logic [2:0]  i_src_bpp,
    input  logic [2:0]  i_dest_bpp,
    input  logic        i_write_ok,
    output logic [31:0] o_data
);

    logic [23:0] rgb;
    logic [7:0]  top;

    always_comb begin
        // three-byte source comes in swapped order
        if (i_src_bpp == BPP_3) begin
            rgb = {i_px[7:0], i_px[15:8], i_px[23:16]};
        end else begin
            rgb = i_px[23:0];
        end
        top    = (i_dest_bpp == BPP_4) ? ALPHA_BYTE : 8'h00;
        o_data = i_write_ok ? {top, rgb} : '0;
    end

endmodule

[rtl/core/clipped_blit_format_convert_core.sv]
// Top level of the clipped blit format convert core: config registers,
// two-stage item pipeline. Depends on cbfc_pkg, cbfc_counter, cbfc_place, cbfc_convert.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one source pixel per item in
//   raster order, i_last flagging the final pixel of the image. The core
//   counts source column and row itself; i_last returns both to zero.
//   Output channel (o_valid / i_stall) carries exactly one result item per
//   input item: write enable, destination byte offset, converted bytes,
//   byte count and the end-of-image copy.
//   Config: write i_cfg_data to register i_cfg_index when i_cfg_we is high.
//   The user must write registers only while the pipe is empty; the core does not enforce it.
// Timing:
//   The accepting edge loads the input register; the result register takes the
//   item when it is free or draining, and o_valid rises as it is loaded.
//   Throughput is one item per clock while i_stall is low; the 13x15 row
//   multiply between the stages sets the critical path.
// Reset:
//   Synchronous, active low. Config returns to 640x480, pitch 2560, 4-byte
//   source and destination, zero offset; pipe empties, counters clear.
// Stall:
//   While i_stall holds a result, the input stage may still take one item;
//   o_stall rises only when both stages are full.
module clipped_blit_format_convert_core
    import cbfc_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [31:0]           i_pixel_bytes,
    input  logic                  i_last,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_write_valid,
    output logic [OFFS_W-1:0]     o_dest_offset,
    output logic [31:0]           o_pixel_data,
    output logic [2:0]            o_byte_count,
    output logic                  o_end_of_image
);

    localparam int CW = $clog2(MAX_DIM);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_width  <= RST_DEST_WIDTH;
            r_cfg.dest_height <= RST_DEST_HEIGHT;
            r_cfg.dest_pitch  <= RST_DEST_PITCH;
            r_cfg.dest_bpp    <= RST_DEST_BPP;
            r_cfg.src_width   <= RST_SRC_WIDTH;
            r_cfg.src_bpp     <= RST_SRC_BPP;
            r_cfg.offset_x    <= '0;
            r_cfg.offset_y    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEST_WIDTH:  r_cfg.dest_width  <= i_cfg_data[12:0];
                CFG_DEST_HEIGHT: r_cfg.dest_height <= i_cfg_data[12:0];
                CFG_DEST_PITCH:  r_cfg.dest_pitch  <= i_cfg_data[14:0];
                CFG_DEST_BPP:    r_cfg.dest_bpp    <= i_cfg_data[2:0];
                CFG_SRC_WIDTH:   r_cfg.src_width   <= i_cfg_data[12:0];
                CFG_SRC_BPP:     r_cfg.src_bpp     <= i_cfg_data[2:0];
                CFG_OFFSET_X:    r_cfg.offset_x    <= $signed(i_cfg_data[13:0]);
                CFG_OFFSET_Y:    r_cfg.offset_y    <= $signed(i_cfg_data[13:0]);
                default: ;
            endcase
        end
    end

    // handshake: stage 1 moves when the result register is free or draining
    logic r_s1_vld;
    logic r_o_vld;
    logic out_free;
    logic s1_adv;
    logic in_acc;

    assign out_free = !r_o_vld || !i_stall;
    assign s1_adv   = r_s1_vld && out_free;
    assign o_stall  = r_s1_vld && !out_free;
    assign in_acc   = i_valid && !o_stall;

    // source position, sampled with the item
    logic [CW-1:0] col;
    logic [CW-1:0] row;

    cbfc_counter #(
        .MAX_DIM (MAX_DIM)
    ) u_counter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (in_acc),
        .i_last      (i_last),
        .i_src_width (r_cfg.src_width),
        .o_col       (col),
        .o_row       (row)
    );

    // stage 1: input register
    logic [31:0]   r_s1_px;
    logic          r_s1_last;
    logic [CW-1:0] r_s1_col;
    logic [CW-1:0] r_s1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px   <= i_pixel_bytes;
            r_s1_last <= i_last;
            r_s1_col  <= col;
            r_s1_row  <= row;
        end
    end

    // stage 2 logic: clip, offset, convert
    t_place      place;
    logic [31:0] conv;

    cbfc_place #(
        .MAX_DIM (MAX_DIM)
    ) u_place (
        .i_cfg   (r_cfg),
        .i_col   (r_s1_col),
        .i_row   (r_s1_row),
        .o_place (place)
    );

    cbfc_convert u_convert (
        .i_px       (r_s1_px),
        .i_src_bpp  (r_cfg.src_bpp),
        .i_dest_bpp (r_cfg.dest_bpp),
        .i_write_ok (place.write_ok),
        .o_data     (conv)
    );

    // result register
    logic              r_o_wr;
    logic [OFFS_W-1:0] r_o_offset;
    logic [31:0]       r_o_data;
    logic [2:0]        r_o_count;
    logic              r_o_eoi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_free) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_wr     <= place.write_ok;
            r_o_offset <= place.offset;
            r_o_data   <= conv;
            r_o_count  <= r_cfg.dest_bpp;
            r_o_eoi    <= r_s1_last;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_write_valid  = r_o_wr;
    assign o_dest_offset  = r_o_offset;
    assign o_pixel_data   = r_o_data;
    assign o_byte_count   = r_o_count;
    assign o_end_of_image = r_o_eoi;

    // checks
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_vld && r_o_vld))
        else $error("input stalled with a free stage");

    a_last_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> (col == '0 && row == '0))
        else $error("position not cleared after last item");

    a_write_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_wr) |-> (r_o_count == BPP_3 || r_o_count == BPP_4))
        else $error("write issued with unsupported format");

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !r_o_wr) |-> (r_o_offset == '0 && r_o_data == '0))
        else $error("clipped item carries nonzero payload");

    a_three_byte_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_count == BPP_3) |-> (r_o_data[31:24] == 8'h00))
        else $error("three-byte output with nonzero top byte");

endmodule

[test/clipped_blit_format_convert_core_tb.sv]
// Self-checking testbench for clipped_blit_format_convert_core: pixel stream in,
// placed and converted write items out, checked against an in-bench predictor.
// Depends on cbfc_pkg and the RTL of the core; nothing else.
`timescale 1ns / 1ps

module clipped_blit_format_convert_core_tb;
    import cbfc_pkg::*;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int SQUEEZE_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;
    localparam int DIM_WRAP       = DEF_MAX_DIM;

    // one write item as the core should emit it
    typedef struct packed {
        logic              write_valid;
        logic [OFFS_W-1:0] dest_offset;
        logic [31:0]       pixel_data;
        logic [2:0]        byte_count;
        logic              end_of_image;
    } t_blit_write;

    // Tracks the surface setup and the source raster position, predicts the
    // write item of each accepted pixel and checks what comes out in order.
    class blit_scoreboard;
        t_cfg          surf;
        logic [11:0]   col;
        logic [11:0]   row;
        t_blit_write   due_q[$];
        int            errors;

        function new();
            surf.dest_width  = RST_DEST_WIDTH;
            surf.dest_height = RST_DEST_HEIGHT;
            surf.dest_pitch  = RST_DEST_PITCH;
            surf.dest_bpp    = RST_DEST_BPP;
            surf.src_width   = RST_SRC_WIDTH;
            surf.src_bpp     = RST_SRC_BPP;
            surf.offset_x    = '0;
            surf.offset_y    = '0;
            col    = '0;
            row    = '0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEST_WIDTH:  surf.dest_width  = val[12:0];
                CFG_DEST_HEIGHT: surf.dest_height = val[12:0];
                CFG_DEST_PITCH:  surf.dest_pitch  = val[14:0];
                CFG_DEST_BPP:    surf.dest_bpp    = val[2:0];
                CFG_SRC_WIDTH:   surf.src_width   = val[12:0];
                CFG_SRC_BPP:     surf.src_bpp     = val[2:0];
                CFG_OFFSET_X:    surf.offset_x    = val[13:0];
                CFG_OFFSET_Y:    surf.offset_y    = val[13:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // place the pixel, clip it, convert it, then step the raster counters
        function void note_pixel(logic [31:0] px, logic lst);
            int                x;
            int                y;
            bit                fmt_good;
            bit                lands;
            longint unsigned   byte_pos;
            logic [7:0]        alpha;
            logic [12:0]       next_col;
            t_blit_write       w;
            fmt_good = (surf.src_bpp == BPP_3 || surf.src_bpp == BPP_4) &&
                       (surf.dest_bpp == BPP_3 || surf.dest_bpp == BPP_4);
            x = $signed({1'b0, col}) + $signed(surf.offset_x);
            y = $signed({1'b0, row}) + $signed(surf.offset_y);
            lands = x >= 0 && y >= 0 &&
                    x < int'(surf.dest_width) && y < int'(surf.dest_height);
            w = '0;
            w.byte_count   = surf.dest_bpp;
            w.end_of_image = lst;
            if (fmt_good && lands) begin
                byte_pos = longint'(y) * surf.dest_pitch + longint'(x) * surf.dest_bpp;
                alpha = (surf.dest_bpp == BPP_4) ? ALPHA_BYTE : 8'h00;
                w.write_valid = 1'b1;
                w.dest_offset = byte_pos[OFFS_W-1:0];
                // three-byte source is stored the other way round
                if (surf.src_bpp == BPP_3)
                    w.pixel_data = {alpha, px[7:0], px[15:8], px[23:16]};
                else
                    w.pixel_data = {alpha, px[23:16], px[15:8], px[7:0]};
            end
            due_q.push_back(w);

            if (lst) begin
                col = '0;
                row = '0;
            end else begin
                next_col = {1'b0, col} + 13'd1;
                if (next_col >= surf.src_width || next_col >= DIM_WRAP) begin
                    col = '0;
                    row = (int'(row) + 1 >= DIM_WRAP) ? '0 : row + 12'd1;
                end else begin
                    col = next_col[11:0];
                end
            end
        endfunction

        function void compare_field(string what, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, what, want, got);
            end
        endfunction

        function void check_write(t_blit_write got);
            t_blit_write want;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing pending, expected none, actual %h",
                             $time, got);
                return;
            end
            want = due_q.pop_front();
            compare_field("write_valid", want.write_valid, got.write_valid);
            compare_field("dest_offset", want.dest_offset, got.dest_offset);
            compare_field("pixel_data", want.pixel_data, got.pixel_data);
            compare_field("byte_count", want.byte_count, got.byte_count);
            compare_field("end_of_image", want.end_of_image, got.end_of_image);
        endfunction
    endclass

    // DUT-side signals, all inputs known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [31:0]           i_pixel_bytes = '0;
    logic                  i_last = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_write_valid;
    logic [OFFS_W-1:0]     o_dest_offset;
    logic [31:0]           o_pixel_data;
    logic [2:0]            o_byte_count;
    logic                  o_end_of_image;

    blit_scoreboard sb = new();

    bit jitter = 1'b1;       // random gaps and stalls on both sides
    bit squeeze_req = 1'b0;  // ask the receiver for one long hold-off
    int stall_left = 0;
    int run_left = 0;
    int quiet_cycles = 0;

    clipped_blit_format_convert_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_bytes  (i_pixel_bytes),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_valid  (o_write_valid),
        .o_dest_offset  (o_dest_offset),
        .o_pixel_data   (o_pixel_data),
        .o_byte_count   (o_byte_count),
        .o_end_of_image (o_end_of_image)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short pauses, now and then a long one
    function automatic int pick_pause();
        int r;
        if (!jitter)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: alternating stall and run stretches. A squeeze request forces
    // one long stall so that both pipe stages fill and o_stall rises.
    always @(negedge i_clk) begin
        if (squeeze_req) begin
            squeeze_req = 1'b0;
            stall_left = SQUEEZE_CYCLES;
            run_left = 0;
        end
        if (stall_left == 0 && run_left == 0) begin
            stall_left = pick_pause();
            run_left = $urandom_range(1, 40);
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            run_left--;
        end
    end

    // Monitor and watchdog: everything is sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_write({o_write_valid, o_dest_offset, o_pixel_data,
                            o_byte_count, o_end_of_image});
        if (i_rst_n && i_valid && !o_stall)
            sb.note_pixel(i_pixel_bytes, i_last);
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("clipped_blit_format_convert_core test failed");
            $finish;
        end
    end

    // offer one pixel from a falling edge until it is taken, then maybe pause
    task automatic send_pixel(input logic [31:0] px, input logic lst);
        int gap;
        i_valid       <= 1'b1;
        i_pixel_bytes <= px;
        i_last        <= lst;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        gap = pick_pause();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // every item yields a result, so an empty queue means an empty pipe
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        sb.set_register(idx, CFG_DATA_W'(val));
        @(negedge i_clk);
    endtask

    // Negative offsets go in as two's complement, truncated to the port width.
    task automatic program_surface(input int dw, input int dh, input int pitch,
                                   input int dbpp, input int sw, input int sbpp,
                                   input int ox, input int oy);
        settle();
        write_register(CFG_DEST_WIDTH, dw);
        write_register(CFG_DEST_HEIGHT, dh);
        write_register(CFG_DEST_PITCH, pitch);
        write_register(CFG_DEST_BPP, dbpp);
        write_register(CFG_SRC_WIDTH, sw);
        write_register(CFG_SRC_BPP, sbpp);
        write_register(CFG_OFFSET_X, ox);
        write_register(CFG_OFFSET_Y, oy);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int mode;
        int sent;
        int images;
        int rows;
        int dw, dh, pitch, dbpp, sw, sbpp, ox, oy;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setup: all land in the top row, byte pattern extremes
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hffff_ffff, 1'b0);
        send_pixel(32'h5555_5555, 1'b0);
        send_pixel(32'haaaa_aaaa, 1'b1);
        send_pixel(32'h0102_0304, 1'b0);
        send_pixel(32'hfedc_ba98, 1'b1);

        // three-byte both ways, left clip, narrow source rows wrapping
        program_surface(2, 3, 6, 3, 3, 3, -1, 1);
        for (int i = 0; i < 6; i++)
            send_pixel($urandom(), i == 5);

        // unsupported source format, then unsupported destination format
        program_surface(640, 480, 2560, 4, 640, 7, 0, 0);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'h8765_4321, 1'b1);
        program_surface(640, 480, 2560, 0, 640, 4, 0, 0);
        send_pixel(32'hcafe_f00d, 1'b1);

        // empty destination and zero source width
        program_surface(0, 0, 1, 4, 0, 4, 0, 0);
        send_pixel(32'hffff_ffff, 1'b0);
        send_pixel(32'h0000_0000, 1'b1);

        // far corner: offset too large for 26 bits, then right clip
        program_surface(8191, 8191, 32767, 4, 4, 3, 8190, 8190);
        send_pixel(32'h00ff_00ff, 1'b0);
        send_pixel(32'hff00_ff00, 1'b1);

        // most negative offsets, everything clipped
        program_surface(8191, 8191, 32767, 3, 8191, 4, -8192, -8192);
        send_pixel(32'h8000_0001, 1'b1);

        // Long receiver hold-off while the sender keeps offering back to back.
        program_surface(12, 8, 48, 4, 10, 3, -2, -1);
        jitter = 1'b0;
        squeeze_req = 1'b1;
        for (int i = 0; i < 120; i++)
            send_pixel($urandom(), (i % 50) == 49);
        sent = 140;

        // Random phases: mostly well-formed images on small surfaces that clip
        // on every side, some raw register values and field extremes.
        while (sent < RANDOM_ITEMS) begin
            jitter = ($urandom_range(0, 4) != 0);
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                program_surface($urandom_range(0, 32767), $urandom_range(0, 32767),
                                $urandom_range(0, 32767), $urandom_range(0, 32767),
                                $urandom_range(0, 32767), $urandom_range(0, 32767),
                                $urandom_range(0, 32767), $urandom_range(0, 32767));
            end else if (mode == 1) begin
                program_surface($urandom_range(0, 1) ? 8191 : $urandom_range(0, 1),
                                $urandom_range(0, 1) ? 8191 : $urandom_range(0, 1),
                                $urandom_range(0, 1) ? 32767 : $urandom_range(0, 1),
                                $urandom_range(0, 1) ? BPP_4 : BPP_3,
                                $urandom_range(0, 1) ? 8191 : $urandom_range(0, 1),
                                $urandom_range(0, 1) ? BPP_4 : BPP_3,
                                $urandom_range(0, 1) ? 8191 : -8192,
                                $urandom_range(0, 1) ? 8191 : -8192);
            end
            if (mode < 2) begin
                for (int i = $urandom_range(30, 80); i > 0; i--) begin
                    send_pixel($urandom(), $urandom_range(0, 15) == 0);
                    sent++;
                end
            end else begin
                dbpp  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                    : $urandom_range(BPP_3, BPP_4);
                sbpp  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                    : $urandom_range(BPP_3, BPP_4);
                dw    = $urandom_range(1, 24);
                dh    = $urandom_range(1, 12);
                pitch = dw * 4 + $urandom_range(0, 16);
                sw    = $urandom_range(1, 20);
                ox    = $urandom_range(0, 40) - 20;
                oy    = $urandom_range(0, 16) - 8;
                program_surface(dw, dh, pitch, dbpp, sw, sbpp, ox, oy);
                images = $urandom_range(1, 3);
                for (int n = 0; n < images; n++) begin
                    rows = $urandom_range(1, dh + 3);
                    // end-of-image on the final pixel, a stray one now and then
                    for (int i = 0; i < rows * sw; i++) begin
                        send_pixel($urandom(),
                                   (i == rows * sw - 1) || ($urandom_range(0, 49) == 0));
                        sent++;
                    end
                end
            end
        end

        settle();
        if (sb.errors == 0)
            $display("clipped_blit_format_convert_core test passed");
        else
            $display("clipped_blit_format_convert_core test failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/cbfc_pkg.sv
rtl/core/cbfc_counter.sv
rtl/core/cbfc_place.sv
rtl/core/cbfc_convert.sv
rtl/core/clipped_blit_format_convert_core.sv
test/clipped_blit_format_convert_core_tb.sv
